// ===== src/mmc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types and codes for the multicycle MIPS control unit: opcodes,
// subfunctions, load enable bits, select codes and the one-hot phase type.
// ----------------------------------------------------------------------------
package mmc_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_HALT    = 6'd12;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_SUB     = 6'h22;

  localparam logic [7:0] LD_PC   = 8'h01;
  localparam logic [7:0] LD_IR   = 8'h02;
  localparam logic [7:0] LD_REG  = 8'h04;
  localparam logic [7:0] LD_MAR  = 8'h08;
  localparam logic [7:0] LD_MDLR = 8'h10;
  localparam logic [7:0] LD_MDSR = 8'h20;
  localparam logic [7:0] MEM_RD  = 8'h40;
  localparam logic [7:0] MEM_WRT = 8'h80;

  localparam logic [2:0] B_FOUR   = 3'd0;
  localparam logic [2:0] B_REG    = 3'd1;
  localparam logic [2:0] B_IMM    = 3'd2;
  localparam logic [2:0] B_IMM_X4 = 3'd3;
  localparam logic [2:0] B_ZERO   = 3'd4;

  localparam logic [1:0] WR_RD  = 2'd0;
  localparam logic [1:0] WR_RT  = 2'd1;
  localparam logic [1:0] WR_R31 = 2'd2;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef enum logic [3:0] {
    PH_FETCH  = 4'b0001,
    PH_DECODE = 4'b0010,
    PH_MEM    = 4'b0100,
    PH_WBACK  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] load_enables;
    logic       pc_sel;
    logic       addr_sel;
    logic       a_sel;
    logic [2:0] b_sel;
    logic       write_data_sel;
    logic [1:0] write_reg_sel;
    logic       alu_op;
  } ctrl_t;

  typedef struct packed {
    ctrl_t  ctrl;
    phase_t phase_next;
    logic   halt_now;
  } dec_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_FETCH:  code = 2'd0;
      PH_DECODE: code = 2'd1;
      PH_MEM:    code = 2'd2;
      PH_WBACK:  code = 2'd3;
      default:   code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== src/mmc_decode.sv =====
// ----------------------------------------------------------------------------
// mmc_decode
// Per-phase decode of the instruction word into load enables, selects,
// ALU function, next phase and a halt request.
// ----------------------------------------------------------------------------
module mmc_decode import mmc_pkg::*; (
  input  logic [31:0] instr,
  input  logic        alu_zero,
  input  phase_t      phase,
  input  logic        halt_flag,
  output dec_t        dec
);

  logic [5:0] op;
  logic [5:0] fn;

  assign op = instr[31:26];
  assign fn = instr[5:0];

  always_comb begin
    dec            = '0;
    dec.phase_next = PH_FETCH;
    if (halt_flag) begin
      dec.phase_next = phase;
    end else begin
      case (phase)
        PH_FETCH: begin
          dec.ctrl.load_enables = MEM_RD | LD_PC | LD_IR;
          dec.ctrl.addr_sel     = 1'b1;
          dec.ctrl.b_sel        = B_FOUR;
          dec.ctrl.alu_op       = ALU_ADD;
          dec.phase_next        = PH_DECODE;
        end
        PH_DECODE: begin
          if (op == OP_J) begin
            dec.ctrl.pc_sel       = 1'b1;
            dec.ctrl.load_enables = LD_PC;
          end else if (op == OP_SPECIAL && fn == FN_ADD) begin
            dec.ctrl.a_sel         = 1'b1;
            dec.ctrl.b_sel         = B_REG;
            dec.ctrl.write_reg_sel = WR_RD;
            dec.ctrl.load_enables  = LD_REG;
          end else if (op == OP_SPECIAL && fn == FN_SUB) begin
            dec.ctrl.a_sel         = 1'b1;
            dec.ctrl.b_sel         = B_REG;
            dec.ctrl.alu_op        = ALU_SUB;
            dec.ctrl.write_reg_sel = WR_RD;
            dec.ctrl.load_enables  = LD_REG;
          end else if (op == OP_ADDI) begin
            dec.ctrl.a_sel         = 1'b1;
            dec.ctrl.b_sel         = B_IMM;
            dec.ctrl.write_reg_sel = WR_RT;
            dec.ctrl.load_enables  = LD_REG;
          end else if (op == OP_LW) begin
            dec.ctrl.a_sel        = 1'b1;
            dec.ctrl.b_sel        = B_IMM;
            dec.ctrl.load_enables = LD_MAR;
            dec.phase_next        = PH_MEM;
          end else if (op == OP_SW) begin
            dec.ctrl.a_sel        = 1'b1;
            dec.ctrl.b_sel        = B_IMM;
            dec.ctrl.load_enables = LD_MAR | LD_MDSR;
            dec.phase_next        = PH_MEM;
          end else if (op == OP_BEQ || op == OP_BNE) begin
            dec.ctrl.a_sel  = 1'b1;
            dec.ctrl.b_sel  = B_REG;
            dec.ctrl.alu_op = ALU_SUB;
            dec.phase_next  = PH_MEM;
          end else if (op == OP_JAL) begin
            dec.ctrl.b_sel         = B_ZERO;
            dec.ctrl.write_reg_sel = WR_R31;
            dec.ctrl.pc_sel        = 1'b1;
            dec.ctrl.load_enables  = LD_REG | LD_PC;
          end else if (op == OP_SPECIAL && fn == FN_JR) begin
            dec.ctrl.a_sel        = 1'b1;
            dec.ctrl.b_sel        = B_ZERO;
            dec.ctrl.load_enables = LD_PC;
          end else begin
            // halt opcode and anything unrecognised
            dec.halt_now   = 1'b1;
            dec.phase_next = phase;
          end
        end
        PH_MEM: begin
          if (op == OP_LW) begin
            dec.ctrl.load_enables = MEM_RD | LD_MDLR;
            dec.phase_next        = PH_WBACK;
          end else if (op == OP_SW) begin
            dec.ctrl.load_enables = MEM_WRT;
          end else if ((op == OP_BEQ && alu_zero) || (op == OP_BNE && !alu_zero)) begin
            dec.ctrl.b_sel        = B_IMM_X4;
            dec.ctrl.load_enables = LD_PC;
          end
        end
        PH_WBACK: begin
          if (op == OP_LW) begin
            dec.ctrl.write_reg_sel  = WR_RT;
            dec.ctrl.write_data_sel = 1'b1;
            dec.ctrl.load_enables   = LD_REG;
          end
        end
        default: begin
          dec.phase_next = PH_FETCH;
        end
      endcase
    end
  end

endmodule

// ===== src/multicycle_mips_control_fsm.sv =====
// ----------------------------------------------------------------------------
// multicycle_mips_control_fsm
// Control unit of a multicycle MIPS subset: phase sequencer, sticky halt
// and cycle counter, with a registered control word per request.
//
//   channel   handshake             payload
//   request   req_valid / req_stall instr, alu_zero
//   result    res_valid / res_stall load_enables .. cycles_so_far
//
// One request per clock unless req_stall; each result is ready the next cycle.
// Decode is one pass of logic from the request ports into the result register.
// rst sets phase to fetch and clears halt flag, cycle counter and result valid.
// req_stall rises only while a result is held and res_stall is high.
// ----------------------------------------------------------------------------
module multicycle_mips_control_fsm import mmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] instr,
  input  logic        alu_zero,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  load_enables,
  output logic        pc_sel,
  output logic        addr_sel,
  output logic        a_sel,
  output logic [2:0]  b_sel,
  output logic        write_data_sel,
  output logic [1:0]  write_reg_sel,
  output logic        alu_op,
  output logic        halted,
  output logic [1:0]  phase_now,
  output logic [31:0] cycles_so_far
);

  phase_t      phase;
  logic        halt_flag;
  logic [31:0] cycle_counter;
  logic        accept;
  logic        halt_next;
  logic [31:0] cycle_counter_next;
  dec_t        dec;
  ctrl_t       ctrl;

  mmc_decode u_decode (
    .instr     (instr),
    .alu_zero  (alu_zero),
    .phase     (phase),
    .halt_flag (halt_flag),
    .dec       (dec)
  );

  assign req_stall          = res_valid && res_stall;
  assign accept             = req_valid && !req_stall;
  assign halt_next          = halt_flag || dec.halt_now;
  assign cycle_counter_next = halt_next ? cycle_counter : cycle_counter + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FETCH;
      halt_flag     <= 1'b0;
      cycle_counter <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        halt_flag     <= halt_next;
        cycle_counter <= cycle_counter_next;
        if (!halt_next) begin
          phase <= dec.phase_next;
        end
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result register: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl          <= dec.ctrl;
      halted        <= halt_next;
      phase_now     <= phase_code(phase);
      cycles_so_far <= cycle_counter_next;
    end
  end

  assign load_enables   = ctrl.load_enables;
  assign pc_sel         = ctrl.pc_sel;
  assign addr_sel       = ctrl.addr_sel;
  assign a_sel          = ctrl.a_sel;
  assign b_sel          = ctrl.b_sel;
  assign write_data_sel = ctrl.write_data_sel;
  assign write_reg_sel  = ctrl.write_reg_sel;
  assign alu_op         = ctrl.alu_op;

endmodule
